### design/rgbfb_pkg.sv
// ----------------------------------------------------------------------------
// rgbfb_pkg
// Shared types and codes of the RGB LED frame buffer: operation codes,
// channel orders, register indexes and the links to the shared scale unit.
// ----------------------------------------------------------------------------
package rgbfb_pkg;

  localparam int CHAN_W      = 8;
  localparam int WORD_W      = 24;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // operation codes carried in in_tuser
  localparam logic [2:0] OP_SET_PIXEL = 3'd0;
  localparam logic [2:0] OP_SET_ALL   = 3'd1;
  localparam logic [2:0] OP_GET_PIXEL = 3'd2;
  localparam logic [2:0] OP_SHOW      = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  // wire channel orders, first letter is the top byte
  localparam logic [2:0] ORD_GRB = 3'd0;
  localparam logic [2:0] ORD_RGB = 3'd1;
  localparam logic [2:0] ORD_BRG = 3'd2;
  localparam logic [2:0] ORD_RBG = 3'd3;
  localparam logic [2:0] ORD_GBR = 3'd4;
  localparam logic [2:0] ORD_BGR = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_LED_COUNT  = 2'd0;
  localparam logic [1:0] REG_CHAN_ORDER = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

  // result kinds carried in out_tuser
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_STRIP = 1'b1;

  typedef enum logic [0:0] {
    ALU_SCALE,
    ALU_UNSCALE
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [CHAN_W-1:0] chan;
    logic [CHAN_W-1:0] bright;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [CHAN_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

### design/rgbfb_alu.sv
// ----------------------------------------------------------------------------
// rgbfb_alu
// Shared channel unit. Scale: chan*bright/255, registered (multiply, then
// reciprocal estimate with one correction). Unscale: (chan*255+bright/2)/
// bright saturated at 255, by restoring division, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rgbfb_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  rgbfb_pkg::alu_req_t req,
  output rgbfb_pkg::alu_rsp_t rsp
);
  import rgbfb_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [2:0]        step_r;
  logic [CHAN_W-1:0] rem_r;
  logic [CHAN_W-1:0] dvd_r;
  logic [CHAN_W-1:0] quo_r;
  logic [CHAN_W-1:0] div_r;
  logic [CHAN_W-1:0] result_r;

  logic [15:0]       prod;
  logic [16:0]       est_sum;
  logic [CHAN_W-1:0] est_q;
  logic [15:0]       est_back;
  logic [15:0]       est_rem;
  logic [CHAN_W-1:0] scale_q;
  logic [15:0]       dividend;
  logic [CHAN_W:0]   rem_sh;
  logic              q_bit;
  logic [CHAN_W-1:0] rem_sub;

  // scale: estimate x/255 as (x + x/256)/256, then correct by one
  assign prod     = 16'(req.chan) * 16'(req.bright);
  assign est_sum  = 17'(prod) + 17'(prod[15:8]);
  assign est_q    = est_sum[15:8];
  assign est_back = {est_q, 8'h00} - 16'(est_q);
  assign est_rem  = prod - est_back;
  assign scale_q  = (est_rem >= 16'(CHAN_MAX)) ? est_q + 8'd1 : est_q;

  // unscale: rounded dividend chan*255 + bright/2
  assign dividend = {req.chan, 8'h00} - 16'(req.chan) + 16'(req.bright >> 1);

  // one restoring division step
  assign rem_sh  = {rem_r, dvd_r[CHAN_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, div_r});
  assign rem_sub = CHAN_W'(rem_sh - {1'b0, div_r});

  // control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        step_r <= '0;
        case (req.op)
          ALU_SCALE: begin
            done_r <= 1'b1;
          end
          ALU_UNSCALE: begin
            if ((req.bright == '0) || (dividend[15:8] >= req.bright)) begin
              done_r <= 1'b1;
            end else begin
              busy_r <= 1'b1;
            end
          end
          default: begin
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // datapath: remainder, dividend bits, quotient, result
  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= q_bit ? rem_sub : rem_sh[CHAN_W-1:0];
      dvd_r <= {dvd_r[CHAN_W-2:0], 1'b0};
      quo_r <= {quo_r[CHAN_W-2:0], q_bit};
      if (step_r == 3'd7) begin
        result_r <= {quo_r[CHAN_W-2:0], q_bit};
      end
    end else if (req.start) begin
      case (req.op)
        ALU_SCALE: begin
          result_r <= scale_q;
        end
        ALU_UNSCALE: begin
          if (req.bright == '0) begin
            result_r <= req.chan;
          end else if (dividend[15:8] >= req.bright) begin
            result_r <= CHAN_MAX;
          end else begin
            rem_r <= dividend[15:8];
            dvd_r <= dividend[7:0];
            div_r <= req.bright;
          end
        end
        default: begin
          result_r <= req.chan;
        end
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = result_r;

endmodule

### design/rgbfb_store.sv
// ----------------------------------------------------------------------------
// rgbfb_store
// Pixel store: one write port, one registered read port. A valid bit per
// entry makes never-written or cleared entries read as zero.
// ----------------------------------------------------------------------------
module rgbfb_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rgbfb_pkg::store_ctl_t         ctl,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [rgbfb_pkg::WORD_W-1:0]  wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [rgbfb_pkg::WORD_W-1:0]  rd_data
);
  import rgbfb_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [WORD_W-1:0] rd_data_r;

  // valid bits: drop all on reset or clear, set on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.clear) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, hold between reads
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/rgb_led_frame_buffer_top.sv
// ----------------------------------------------------------------------------
// rgb_led_frame_buffer_top
// Frame buffer for a chain of addressable RGB LEDs, with a sequencer that
// drives one shared scale/unscale unit and a registered-read pixel store.
// ----------------------------------------------------------------------------
// Set pixel: three scale passes (request, then wait for the unit), then a write.
// Set all: three scale passes, then a fill that writes every LED in use.
// Get pixel: a store read, then three bit-serial unscale passes; a miss skips both.
// Show: per LED, store read, then output register; clear empties, then shows.
// One item at a time; in_tready is high only while the sequencer is idle.
// Reset: synchronous, clears all valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_led_frame_buffer_top #(
  parameter int MAX_LEDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: index[5:0], red[13:6], green[21:14], blue[29:22], zero pad
  input  logic [rgbfb_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser: operation[2:0]
  input  logic [2:0]  in_tuser,
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: strip_word[31:0], read_red[39:32], read_green[47:40],
  //            read_blue[55:48], hit[56], zero pad
  output logic [rgbfb_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: kind[0]
  output logic        out_tuser,
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rgbfb_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam logic [1:0] CH_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE_REQ,
    S_SCALE_WAIT,
    S_WRITE,
    S_FILL,
    S_RD_REQ,
    S_UNS_REQ,
    S_UNS_WAIT,
    S_EMIT,
    S_CLEAR,
    S_SHOW_RD,
    S_SHOW_WR
  } state_t;

  function automatic logic [WORD_W-1:0] pack_word(
    input logic [2:0]        ord,
    input logic [CHAN_W-1:0] r,
    input logic [CHAN_W-1:0] g,
    input logic [CHAN_W-1:0] b
  );
    logic [WORD_W-1:0] w;
    case (ord)
      ORD_RGB: w = {r, g, b};
      ORD_BRG: w = {b, r, g};
      ORD_RBG: w = {r, b, g};
      ORD_GBR: w = {g, b, r};
      ORD_BGR: w = {b, g, r};
      default: w = {g, r, b};
    endcase
    return w;
  endfunction

  // returns {red, green, blue}
  function automatic logic [WORD_W-1:0] unpack_word(
    input logic [2:0]        ord,
    input logic [WORD_W-1:0] w
  );
    logic [WORD_W-1:0] c;
    case (ord)
      ORD_RGB: c = w;
      ORD_BRG: c = {w[15:8], w[7:0], w[23:16]};
      ORD_RBG: c = {w[23:16], w[7:0], w[15:8]};
      ORD_GBR: c = {w[7:0], w[23:16], w[15:8]};
      ORD_BGR: c = {w[7:0], w[15:8], w[23:16]};
      default: c = {w[15:8], w[23:16], w[7:0]};
    endcase
    return c;
  endfunction

  // configuration registers
  logic [6:0]        led_count_r;
  logic [2:0]        chan_order_r;
  logic [CHAN_W-1:0] bright_r;

  // sequencer state and item registers
  state_t            state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [5:0]        idx_r, idx_nxt;
  logic [CHAN_W-1:0] red_r, red_nxt;
  logic [CHAN_W-1:0] green_r, green_nxt;
  logic [CHAN_W-1:0] blue_r, blue_nxt;
  logic              hit_r, hit_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CHAN_W-1:0] res0_r, res0_nxt;
  logic [CHAN_W-1:0] res1_r, res1_nxt;
  logic [CHAN_W-1:0] res2_r, res2_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [31:0]       out_word_r, out_word_nxt;
  logic [CHAN_W-1:0] out_red_r, out_red_nxt;
  logic [CHAN_W-1:0] out_green_r, out_green_nxt;
  logic [CHAN_W-1:0] out_blue_r, out_blue_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CW-1:0]     eff_n;
  logic              in_hit;
  logic              ptr_last;
  logic              out_free;
  logic [WORD_W-1:0] packed_word;
  logic [WORD_W-1:0] unpacked;
  logic [CHAN_W-1:0] scale_chan;
  logic [CHAN_W-1:0] uns_chan;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  store_ctl_t        st_ctl;
  logic [AW-1:0]     st_wr_addr;
  logic [AW-1:0]     st_rd_addr;
  logic [WORD_W-1:0] st_rd_data;

  // effective count: led_count saturated at the store depth
  assign eff_n    = (led_count_r > 7'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(led_count_r);
  assign in_hit   = (7'(in_tdata[5:0]) < 7'(eff_n));
  assign ptr_last = ((CW'(ptr_r) + CW'(1)) == eff_n);
  assign out_free = !out_valid_r || out_tready;

  assign packed_word = pack_word(chan_order_r, res0_r, res1_r, res2_r);
  assign unpacked    = unpack_word(chan_order_r, st_rd_data);

  // pick the channel fed to the shared unit
  always_comb begin
    case (ch_r)
      2'd0:    scale_chan = red_r;
      2'd1:    scale_chan = green_r;
      default: scale_chan = blue_r;
    endcase
    case (ch_r)
      2'd0:    uns_chan = unpacked[23:16];
      2'd1:    uns_chan = unpacked[15:8];
      default: uns_chan = unpacked[7:0];
    endcase
  end

  assign alu_req.start  = (state_r == S_SCALE_REQ) || (state_r == S_UNS_REQ);
  assign alu_req.op     = (state_r == S_UNS_REQ) ? ALU_UNSCALE : ALU_SCALE;
  assign alu_req.chan   = (state_r == S_UNS_REQ) ? uns_chan : scale_chan;
  assign alu_req.bright = bright_r;

  assign st_ctl.clear = (state_r == S_CLEAR);
  assign st_ctl.wr_en = ((state_r == S_WRITE) && (op_r == OP_SET_PIXEL) && hit_r) ||
                        (state_r == S_FILL);
  assign st_ctl.rd_en = (state_r == S_RD_REQ) || (state_r == S_SHOW_RD);
  assign st_wr_addr   = (state_r == S_FILL) ? ptr_r : AW'(idx_r);
  assign st_rd_addr   = (state_r == S_SHOW_RD) ? ptr_r : AW'(idx_r);

  rgbfb_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  rgbfb_store #(
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .wr_addr (st_wr_addr),
    .wr_data (packed_word),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    hit_nxt       = hit_r;
    ch_nxt        = ch_r;
    ptr_nxt       = ptr_r;
    res0_nxt      = res0_r;
    res1_nxt      = res1_r;
    res2_nxt      = res2_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_word_nxt  = out_word_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    out_hit_nxt   = out_hit_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          idx_nxt   = in_tdata[5:0];
          red_nxt   = in_tdata[13:6];
          green_nxt = in_tdata[21:14];
          blue_nxt  = in_tdata[29:22];
          hit_nxt   = in_hit;
          ch_nxt    = '0;
          ptr_nxt   = '0;
          case (in_tuser)
            OP_SET_PIXEL, OP_SET_ALL: begin
              state_nxt = S_SCALE_REQ;
            end
            OP_GET_PIXEL: begin
              if (in_hit) begin
                state_nxt = S_RD_REQ;
              end else begin
                res0_nxt  = '0;
                res1_nxt  = '0;
                res2_nxt  = '0;
                state_nxt = S_EMIT;
              end
            end
            OP_SHOW: begin
              state_nxt = (eff_n == '0) ? S_IDLE : S_SHOW_RD;
            end
            OP_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCALE_REQ: begin
        state_nxt = S_SCALE_WAIT;
      end
      S_UNS_REQ: begin
        state_nxt = S_UNS_WAIT;
      end
      S_SCALE_WAIT, S_UNS_WAIT: begin
        // store the channel and advance to the next one
        if (alu_rsp.done) begin
          case (ch_r)
            2'd0:    res0_nxt = alu_rsp.result;
            2'd1:    res1_nxt = alu_rsp.result;
            default: res2_nxt = alu_rsp.result;
          endcase
          if (ch_r == CH_LAST) begin
            state_nxt = (state_r == S_SCALE_WAIT) ? S_WRITE : S_EMIT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = (state_r == S_SCALE_WAIT) ? S_SCALE_REQ : S_UNS_REQ;
          end
        end
      end
      S_WRITE: begin
        if ((op_r == OP_SET_ALL) && (eff_n != '0)) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        if (ptr_last) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_RD_REQ: begin
        state_nxt = S_UNS_REQ;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_READ;
          out_word_nxt  = '0;
          out_red_nxt   = res0_r;
          out_green_nxt = res1_r;
          out_blue_nxt  = res2_r;
          out_hit_nxt   = hit_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_CLEAR: begin
        state_nxt = (eff_n == '0) ? S_IDLE : S_SHOW_RD;
      end
      S_SHOW_RD: begin
        state_nxt = S_SHOW_WR;
      end
      S_SHOW_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_STRIP;
          out_word_nxt  = {st_rd_data, 8'h00};
          out_red_nxt   = '0;
          out_green_nxt = '0;
          out_blue_nxt  = '0;
          out_hit_nxt   = 1'b0;
          out_last_nxt  = ptr_last;
          if (ptr_last) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_SHOW_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      led_count_r  <= 7'd64;
      chan_order_r <= ORD_GRB;
      bright_r     <= CHAN_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_LED_COUNT:  led_count_r  <= cfg_data[6:0];
          REG_CHAN_ORDER: chan_order_r <= cfg_data[2:0];
          REG_BRIGHTNESS: bright_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    red_r       <= red_nxt;
    green_r     <= green_nxt;
    blue_r      <= blue_nxt;
    hit_r       <= hit_nxt;
    ch_r        <= ch_nxt;
    ptr_r       <= ptr_nxt;
    res0_r      <= res0_nxt;
    res1_r      <= res1_nxt;
    res2_r      <= res2_nxt;
    out_kind_r  <= out_kind_nxt;
    out_word_r  <= out_word_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_hit_r   <= out_hit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'h00, out_hit_r, out_blue_r, out_green_r, out_red_r, out_word_r};

endmodule

### design/rgbfb_checker.sv
// ----------------------------------------------------------------------------
// rgbfb_checker
// Port-level checks of the frame buffer's result beats, bound to the top.
// ----------------------------------------------------------------------------
module rgbfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);
  import rgbfb_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // read-back beats never close a run
  a_read_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_READ) |-> !out_tlast)
    else $error("read-back beat marked last");

  // strip beats carry no colour or hit, and a zero low byte
  a_strip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_STRIP) |->
    (out_tdata[56:32] == '0) && (out_tdata[7:0] == 8'h00))
    else $error("strip beat carries read-back fields");

  // a missed read returns all zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_READ) && !out_tdata[56] |->
    (out_tdata[55:0] == '0))
    else $error("missed read-back carries data");

endmodule

bind rgb_led_frame_buffer_top rgbfb_checker u_rgbfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
